>>> hdl/key_debounce_event_generator_assert.svh
// Assertion helpers for the RTL file that carries checks, the top-level module.
// Both forms sample on the rising edge of clk and are off while rst_n is low.
`ifndef KEY_DEBOUNCE_EVENT_GENERATOR_ASSERT_SVH
`define KEY_DEBOUNCE_EVENT_GENERATOR_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define KDEG_ASSERT_SAME(label, trig, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
        else $error("key debounce assertion failed");

// The condition must hold in the cycle after the trigger.
`define KDEG_ASSERT_NEXT(label, trig, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error("key debounce assertion failed");

`endif

>>> hdl/kdeg_pkg.sv
`default_nettype none

package kdeg_pkg;

    localparam int NUM_KEYS_DEF = 24;
    localparam int KEY_INDEX_W  = 5;
    localparam int CODE_W       = 8;
    localparam int FILTER_W     = 7;
    localparam int LONG_W       = 16;
    localparam int REPEAT_W     = 8;
    localparam int DEB_W        = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [FILTER_W-1:0] FILTER_TIME_RST  = 7'd5;
    localparam logic [LONG_W-1:0]   LONG_TIME_RST    = 16'd100;
    localparam logic [REPEAT_W-1:0] REPEAT_SPEED_RST = 8'd0;
    localparam logic [DEB_W-1:0]    DEB_COUNT_RST    = DEB_W'(FILTER_TIME_RST / 2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_TIME  = 2'd0,
        REG_LONG_TIME    = 2'd1,
        REG_REPEAT_SPEED = 2'd2
    } reg_idx_t;

    // The encoding doubles as the offset added to three times the key number.
    typedef enum logic [1:0] {
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2,
        EV_LONG    = 2'd3
    } ev_kind_t;

    typedef struct packed {
        logic [FILTER_W-1:0] filter_time;
        logic [LONG_W-1:0]   long_time;
        logic [REPEAT_W-1:0] repeat_speed;
    } cfg_t;

    // One or two events caused by a single sample.
    typedef struct packed {
        logic [KEY_INDEX_W-1:0] key;
        ev_kind_t               kind0;
        ev_kind_t               kind1;
        logic                   two;
    } ev_rec_t;

endpackage

`default_nettype wire

>>> hdl/kdeg_sample_if.sv
`default_nettype none

interface kdeg_sample_if;
    import kdeg_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [KEY_INDEX_W-1:0] key_index;
    logic                   pressed;

    modport source (output valid, output key_index, output pressed, input ready);
    modport sink (input valid, input key_index, input pressed, output ready);
endinterface

`default_nettype wire

>>> hdl/kdeg_event_if.sv
`default_nettype none

interface kdeg_event_if;
    import kdeg_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] key_code;
    logic              is_last;

    modport source (output valid, output key_code, output is_last, input ready);
    modport sink (input valid, input key_code, input is_last, output ready);
endinterface

`default_nettype wire

>>> hdl/kdeg_fifo.sv
`default_nettype none

module kdeg_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = kdeg_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/kdeg_front.sv
`default_nettype none

module kdeg_front #(
    parameter int NUM_KEYS = kdeg_pkg::NUM_KEYS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    kdeg_sample_if.sink       sample,
    input  kdeg_pkg::cfg_t    cfg,
    input  logic              queue_full,
    output logic              push,
    output kdeg_pkg::ev_rec_t rec
);
    import kdeg_pkg::*;

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [DEB_W-1:0]    deb_count_reg [NUM_KEYS];
    logic                down_reg      [NUM_KEYS];
    logic [LONG_W-1:0]   hold_reg      [NUM_KEYS];
    logic [REPEAT_W-1:0] rep_reg       [NUM_KEYS];

    logic [DEB_W-1:0]    deb_count_next;
    logic                down_next;
    logic [LONG_W-1:0]   hold_next;
    logic [REPEAT_W-1:0] rep_next;

    logic [KEY_W-1:0]    idx;
    logic                key_ok;
    logic                accept;
    logic [DEB_W-1:0]    cnt;
    logic [DEB_W-1:0]    f_lo;
    logic [DEB_W-1:0]    f_hi;
    logic [REPEAT_W-1:0] rep_inc;
    logic                press_ev;
    logic                release_ev;
    logic                later_ev;
    ev_kind_t            later_kind;

    assign key_ok       = int'(sample.key_index) < NUM_KEYS;
    assign idx          = key_ok ? KEY_W'(sample.key_index) : '0;
    assign sample.ready = !queue_full;
    assign accept       = sample.valid && sample.ready;

    assign cnt     = deb_count_reg[idx];
    assign f_lo    = {1'b0, cfg.filter_time};
    assign f_hi    = {cfg.filter_time, 1'b0};
    assign rep_inc = rep_reg[idx] + 1'b1;

    // Hysteresis debounce, then hold and repeat timing, for the sampled key.
    always_comb
    begin
        deb_count_next = cnt;
        down_next      = down_reg[idx];
        hold_next      = hold_reg[idx];
        rep_next       = rep_reg[idx];
        press_ev       = 1'b0;
        release_ev     = 1'b0;
        later_ev       = 1'b0;
        later_kind     = EV_LONG;
        if (sample.pressed)
        begin
            if (cnt < f_lo)
            begin
                deb_count_next = f_lo;
            end
            else if (cnt < f_hi)
            begin
                deb_count_next = cnt + 1'b1;
            end
            else
            begin
                if (!down_reg[idx])
                begin
                    down_next = 1'b1;
                    press_ev  = 1'b1;
                end
                if (cfg.long_time != '0)
                begin
                    if (hold_reg[idx] < cfg.long_time)
                    begin
                        hold_next = hold_reg[idx] + 1'b1;
                        if (hold_next == cfg.long_time)
                        begin
                            later_ev   = 1'b1;
                            later_kind = EV_LONG;
                        end
                    end
                    else if (cfg.repeat_speed != '0)
                    begin
                        if (rep_inc >= cfg.repeat_speed)
                        begin
                            rep_next   = '0;
                            later_ev   = 1'b1;
                            later_kind = EV_PRESS;
                        end
                        else
                        begin
                            rep_next = rep_inc;
                        end
                    end
                end
            end
        end
        else
        begin
            if (cnt > f_lo)
            begin
                deb_count_next = f_lo;
            end
            else if (cnt != '0)
            begin
                deb_count_next = cnt - 1'b1;
            end
            else if (down_reg[idx])
            begin
                down_next  = 1'b0;
                release_ev = 1'b1;
            end
            hold_next = '0;
            rep_next  = '0;
        end
    end

    // A sample causes at most one leading press followed by one long-press or repeat.
    always_comb
    begin
        rec.key   = sample.key_index;
        rec.two   = press_ev && later_ev;
        rec.kind1 = later_kind;
        if (press_ev)
        begin
            rec.kind0 = EV_PRESS;
        end
        else if (release_ev)
        begin
            rec.kind0 = EV_RELEASE;
        end
        else
        begin
            rec.kind0 = later_kind;
        end
        push = accept && key_ok && (press_ev || release_ev || later_ev);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                deb_count_reg[k] <= DEB_COUNT_RST;
                down_reg[k]      <= 1'b0;
                hold_reg[k]      <= '0;
                rep_reg[k]       <= '0;
            end
        end
        else if (accept && key_ok)
        begin
            deb_count_reg[idx] <= deb_count_next;
            down_reg[idx]      <= down_next;
            hold_reg[idx]      <= hold_next;
            rep_reg[idx]       <= rep_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/kdeg_back.sv
`default_nettype none

module kdeg_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_empty,
    input  kdeg_pkg::ev_rec_t head,
    output logic              pop,
    kdeg_event_if.source      key_event
);
    import kdeg_pkg::*;

    function automatic logic [CODE_W-1:0] event_code(
        input logic [KEY_INDEX_W-1:0] key,
        input ev_kind_t               kind
    );
        logic [CODE_W-1:0] k8;
        k8 = CODE_W'(key);
        return (k8 << 1) + k8 + CODE_W'(kind);
    endfunction

    ev_rec_t           rec_reg, rec_next;
    logic              rec_valid_reg, rec_valid_next;
    logic              second_reg, second_next;
    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic              emit;
    logic              emit_last;

    assign out_free  = !out_valid_reg || key_event.ready;
    assign emit      = rec_valid_reg && out_free;
    assign emit_last = second_reg || !rec_reg.two;
    assign pop       = !queue_empty && (!rec_valid_reg || (emit && emit_last));

    assign key_event.valid    = out_valid_reg;
    assign key_event.key_code = code_reg;
    assign key_event.is_last  = last_reg;

    always_comb
    begin
        rec_next       = rec_reg;
        rec_valid_next = rec_valid_reg;
        second_next    = second_reg;
        if (emit)
        begin
            if (emit_last)
            begin
                rec_valid_next = 1'b0;
                second_next    = 1'b0;
            end
            else
            begin
                second_next = 1'b1;
            end
        end
        if (pop)
        begin
            rec_next       = head;
            rec_valid_next = 1'b1;
            second_next    = 1'b0;
        end

        out_valid_next = out_valid_reg;
        code_next      = code_reg;
        last_next      = last_reg;
        if (out_free)
        begin
            out_valid_next = emit;
            code_next      = event_code(rec_reg.key, second_reg ? rec_reg.kind1 : rec_reg.kind0);
            last_next      = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rec_valid_reg <= rec_valid_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg  <= rec_next;
        code_reg <= code_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

>>> hdl/key_debounce_event_generator.sv
// Accepts one scan sample per cycle while the event queue is not full; the per-key state
// is updated in the accept cycle. Events pass through the queue, record and output registers.
// Events leave at up to one per cycle while the sink is ready; a sample's two events go in order.
// A four-entry event queue sits between the per-key update and the output register.
// Reset: registers return to 5/100/0, every key is released with debounce count 2, and the
// block accepts samples in the first cycle after reset.
`default_nettype none

`include "key_debounce_event_generator_assert.svh"

module key_debounce_event_generator #(
    parameter int NUM_KEYS = kdeg_pkg::NUM_KEYS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    kdeg_sample_if.sink                        sample,
    kdeg_event_if.source                       key_event,
    input  logic                               wr_en,
    input  logic [kdeg_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [kdeg_pkg::CFG_DATA_W-1:0]    wr_data
);
    import kdeg_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    ev_rec_t front_rec;
    ev_rec_t queue_head;
    logic    fifo_push;
    logic    fifo_pop;
    logic    fifo_full;
    logic    fifo_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_FILTER_TIME:  cfg_next.filter_time  = wr_data[FILTER_W-1:0];
                REG_LONG_TIME:    cfg_next.long_time    = wr_data[LONG_W-1:0];
                REG_REPEAT_SPEED: cfg_next.repeat_speed = wr_data[REPEAT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_time  <= FILTER_TIME_RST;
            cfg_reg.long_time    <= LONG_TIME_RST;
            cfg_reg.repeat_speed <= REPEAT_SPEED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    kdeg_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .cfg        (cfg_reg),
        .queue_full (fifo_full),
        .push       (fifo_push),
        .rec        (front_rec)
    );

    kdeg_fifo #(
        .WIDTH ($bits(ev_rec_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (front_rec),
        .pop       (fifo_pop),
        .pop_data  (queue_head),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    kdeg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (fifo_empty),
        .head        (queue_head),
        .pop         (fifo_pop),
        .key_event   (key_event)
    );

    `KDEG_ASSERT_SAME(a_no_overflow, fifo_push, !fifo_full)
    `KDEG_ASSERT_SAME(a_pair_leads_with_press, fifo_push && front_rec.two,
        front_rec.kind0 == EV_PRESS)
    `KDEG_ASSERT_SAME(a_bad_key_silent,
        sample.valid && sample.ready && (int'(sample.key_index) >= NUM_KEYS), !fifo_push)
    `KDEG_ASSERT_NEXT(a_push_fills_queue, fifo_push, !fifo_empty)

endmodule

`default_nettype wire

>>> sim/tb_key_debounce_event_generator.sv
`default_nettype none

module tb_key_debounce_event_generator;
    import kdeg_pkg::*;

    localparam int KEYS        = NUM_KEYS_DEF;
    localparam int CYCLE_LIMIT = 500000;
    // Idle margin after the last expected event has been checked.
    localparam int SETTLE      = 8;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic              last;
    } key_code_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    kdeg_sample_if sample_ch();
    kdeg_event_if  event_ch();

    key_debounce_event_generator #(.NUM_KEYS(KEYS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch.sink),
        .key_event (event_ch.source),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the register file and the per-key debounce state.
    logic [FILTER_W-1:0] filter_shadow;
    logic [LONG_W-1:0]   long_shadow;
    logic [REPEAT_W-1:0] repeat_shadow;
    logic [DEB_W-1:0]    deb_level [KEYS];
    logic                key_down [KEYS];
    logic [LONG_W-1:0]   held_ticks [KEYS];
    logic [REPEAT_W-1:0] repeat_ticks [KEYS];

    key_code_t   pending_codes[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          src_idle_on = 1'b0;
    bit          sink_idle_on = 1'b0;
    int unsigned hold_off_len = 0;

    function automatic void reset_key_state();
        filter_shadow = FILTER_TIME_RST;
        long_shadow   = LONG_TIME_RST;
        repeat_shadow = REPEAT_SPEED_RST;
        for (int k = 0; k < KEYS; k++)
        begin
            deb_level[k]    = DEB_COUNT_RST;
            key_down[k]     = 1'b0;
            held_ticks[k]   = '0;
            repeat_ticks[k] = '0;
        end
    endfunction

    function automatic logic [CODE_W-1:0] code_of(input int unsigned k, input ev_kind_t kind);
        return CODE_W'(3 * k + int'(kind));
    endfunction

    // Updates one key for one scan sample and queues the events it causes.
    function automatic void predict_key_events(input logic [KEY_INDEX_W-1:0] key,
                                               input logic level);
        int unsigned k;
        int unsigned cnt;
        int unsigned f;
        int unsigned r;
        int          n;
        logic [CODE_W-1:0] codes [2];
        key_code_t   item;
        k = key;
        n = 0;
        if (k >= KEYS)
            return;
        cnt = deb_level[k];
        f = filter_shadow;
        if (level)
        begin
            if (cnt < f)
                deb_level[k] = DEB_W'(f);
            else if (cnt < 2 * f)
                deb_level[k] = DEB_W'(cnt + 1);
            else
            begin
                if (!key_down[k])
                begin
                    key_down[k] = 1'b1;
                    codes[n] = code_of(k, EV_PRESS);
                    n++;
                end
                if (long_shadow != 0)
                begin
                    if (held_ticks[k] < long_shadow)
                    begin
                        held_ticks[k] = held_ticks[k] + 1'b1;
                        if (held_ticks[k] == long_shadow)
                        begin
                            codes[n] = code_of(k, EV_LONG);
                            n++;
                        end
                    end
                    else if (repeat_shadow != 0)
                    begin
                        r = (repeat_ticks[k] + 1) & 8'hFF;
                        if (r >= repeat_shadow)
                        begin
                            repeat_ticks[k] = '0;
                            codes[n] = code_of(k, EV_PRESS);
                            n++;
                        end
                        else
                            repeat_ticks[k] = REPEAT_W'(r);
                    end
                end
            end
        end
        else
        begin
            if (cnt > f)
                deb_level[k] = DEB_W'(f);
            else if (cnt != 0)
                deb_level[k] = DEB_W'(cnt - 1);
            else if (key_down[k])
            begin
                key_down[k] = 1'b0;
                codes[n] = code_of(k, EV_RELEASE);
                n++;
            end
            held_ticks[k]   = '0;
            repeat_ticks[k] = '0;
        end
        for (int i = 0; i < n; i++)
        begin
            item.code = codes[i];
            item.last = (i == n - 1);
            pending_codes.push_back(item);
        end
    endfunction

    // Register writes, sample acceptance and event checking, all at the clock edge.
    always @(posedge clk)
    begin : monitor
        key_code_t want;
        if (rst_n)
        begin
            if (wr_en)
            begin
                case (reg_idx_t'(wr_index))
                    REG_FILTER_TIME:  filter_shadow = wr_data[FILTER_W-1:0];
                    REG_LONG_TIME:    long_shadow   = wr_data[LONG_W-1:0];
                    REG_REPEAT_SPEED: repeat_shadow = wr_data[REPEAT_W-1:0];
                    default: ;
                endcase
            end
            if (sample_ch.valid && sample_ch.ready)
                predict_key_events(sample_ch.key_index, sample_ch.pressed);
            if (event_ch.valid && event_ch.ready)
            begin
                if (pending_codes.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected event: expected none, got code %0d last %0b",
                             $time, event_ch.key_code, event_ch.is_last);
                end
                else
                begin
                    want = pending_codes.pop_front();
                    if (event_ch.key_code !== want.code || event_ch.is_last !== want.last)
                    begin
                        error_count++;
                        $display("%0t: event mismatch: expected code %0d last %0b, got code %0d last %0b",
                                 $time, want.code, want.last, event_ch.key_code, event_ch.is_last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Event sink: random stall bursts, plus one long hold-off on request.
    initial
    begin : event_sink
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                event_ch.ready <= 1'b0;
            end
            else if (hold_off_len != 0)
            begin
                stall_left = hold_off_len - 1;
                hold_off_len <= 0;
                event_ch.ready <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                event_ch.ready <= 1'b0;
            end
            else
                event_ch.ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [KEY_INDEX_W-1:0] key, input logic level);
        int unsigned gap;
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.key_index <= key;
        sample_ch.pressed   <= level;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_run(input logic [KEY_INDEX_W-1:0] key, input logic level,
                            input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_sample(key, level);
    endtask

    // The first edge lets the monitor record the events of the last accepted item.
    task automatic wait_for_events();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic set_config(input int unsigned filt, input int unsigned hold,
                              input int unsigned rpt);
        wr_en    <= 1'b1;
        wr_index <= REG_FILTER_TIME;
        wr_data  <= CFG_DATA_W'(filt);
        @(posedge clk);
        wr_index <= REG_LONG_TIME;
        wr_data  <= CFG_DATA_W'(hold);
        @(posedge clk);
        wr_index <= REG_REPEAT_SPEED;
        wr_data  <= CFG_DATA_W'(rpt);
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_ignored_keys();
        send_sample(5'd24, 1'b1);
        send_sample(5'd31, 1'b1);
        send_sample(5'd31, 1'b0);
        send_sample(5'd24, 1'b0);
        wait_for_events();
    endtask

    // With a zero filter a pressed sample is stable at once; a long time of one
    // makes the first stable sample give both press and long press.
    task automatic test_filter_zero();
        set_config(0, 1, 1);
        send_sample(5'd0, 1'b1);
        send_sample(5'd0, 1'b1);
        send_sample(5'd0, 1'b0);
        send_sample(5'd0, 1'b0);
        send_sample(5'd23, 1'b1);
        send_sample(5'd23, 1'b0);
        send_sample(5'd23, 1'b0);
        wait_for_events();
    endtask

    task automatic test_hysteresis();
        set_config(2, 3, 2);
        send_sample(5'd5, 1'b1);
        send_sample(5'd5, 1'b0);
        send_run(5'd5, 1'b1, 7);
        send_run(5'd5, 1'b0, 4);
        // Leave key 9 stable down with its hold count at the limit.
        send_run(5'd9, 1'b1, 6);
        wait_for_events();
    endtask

    // Counters are not cleared by a register write: key 9 sits above the new
    // range and its hold count already exceeds the new long time.
    task automatic test_reconfig_running();
        set_config(1, 2, 3);
        send_run(5'd9, 1'b1, 4);
        send_run(5'd9, 1'b0, 3);
        wait_for_events();
    endtask

    task automatic test_backpressure();
        set_config(0, 1, 1);
        hold_off_len <= 80;
        send_run(5'd3, 1'b1, 24);
        send_run(5'd3, 1'b0, 2);
        wait_for_events();
    endtask

    // Mostly complete press and release gestures on one key, mixed with noise.
    task automatic random_gestures(input int unsigned budget);
        int unsigned counted;
        int unsigned f;
        int unsigned span;
        int unsigned run;
        int unsigned n;
        logic [KEY_INDEX_W-1:0] key;
        counted = 0;
        while (counted < budget)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                key = KEY_INDEX_W'($urandom_range(0, KEYS - 1));
                f = filter_shadow;
                span = long_shadow + 2 * repeat_shadow;
                if (span > 60)
                    span = 60;
                run = $urandom_range(f / 2, 2 * f + span + 3);
                for (int unsigned i = 0; i < run; i++)
                    send_sample(key, $urandom_range(0, 19) != 0);
                counted += run;
                run = $urandom_range(f / 2, 2 * f + 3);
                for (int unsigned i = 0; i < run; i++)
                    send_sample(key, $urandom_range(0, 19) == 0);
                counted += run;
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int unsigned i = 0; i < n; i++)
                begin
                    key = KEY_INDEX_W'($urandom_range(0, 31));
                    send_sample(key, 1'($urandom_range(0, 1)));
                    if (key < KEYS)
                        counted++;
                end
            end
        end
        wait_for_events();
    endtask

    task automatic test_random_settings();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        set_config(1, 4, 2);
        random_gestures(220);
        set_config(3, 0, 2);
        random_gestures(200);
        set_config(2, 6, 255);
        random_gestures(200);
        set_config(4, 12, 1);
        random_gestures(200);
        set_config(0, 3, 1);
        random_gestures(200);
    endtask

    task automatic test_extreme_settings();
        set_config(127, 65535, 255);
        random_gestures(250);
    endtask

    task automatic test_quiet_finish();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        set_config(2, 5, 2);
        random_gestures(180);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        wr_en               = 1'b0;
        wr_index            = REG_FILTER_TIME;
        wr_data             = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.key_index = '0;
        sample_ch.pressed   = 1'b0;
        event_ch.ready      = 1'b0;
        reset_key_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_ignored_keys();
        test_filter_zero();
        test_hysteresis();
        test_reconfig_running();
        test_backpressure();
        test_random_settings();
        test_extreme_settings();
        test_quiet_finish();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
